### design/missing_channel_interpolator_defines.svh
// Assertion macros shared by the interpolator's checker.
// No dependencies; included by design/mci_checker.sv.
`ifndef MISSING_CHANNEL_INTERPOLATOR_DEFINES_SVH
`define MISSING_CHANNEL_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define MCI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define MCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define MCI_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mci_pkg.sv
// Shared types, constants and the weight table of the missing-channel interpolator.
// No dependencies; used by every module of the block.
package mci_pkg;

   localparam int NUM_POSITIONS  = 8;
   localparam int SAMPLE_BITS    = 16;
   localparam int SEL_BITS       = 3;
   localparam int POS_BITS       = 3;
   localparam int FRAC_BITS      = 16;
   localparam int PROD_BITS      = SAMPLE_BITS + FRAC_BITS + 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;
   localparam int MASK_BITS      = NUM_POSITIONS;
   localparam int SELECT_BITS    = SEL_BITS * NUM_POSITIONS;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROVIDED_MASK = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_SELECT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_SELECT   = 2'd2;

   // Register reset values
   localparam logic [MASK_BITS-1:0]   PROVIDED_MASK_RESET = 8'd137;
   localparam logic [SELECT_BITS-1:0] SELECT_RESET        = 24'd16434824;

   // One half LSB of the result in product units
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
      {{(PROD_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type sample_in_7;
      sample_type sample_in_6;
      sample_type sample_in_5;
      sample_type sample_in_4;
      sample_type sample_in_3;
      sample_type sample_in_2;
      sample_type sample_in_1;
      sample_type sample_in_0;
   } req_payload_type;

   typedef struct packed {
      sample_type sample_out_7;
      sample_type sample_out_6;
      sample_type sample_out_5;
      sample_type sample_out_4;
      sample_type sample_out_3;
      sample_type sample_out_2;
      sample_type sample_out_1;
      sample_type sample_out_0;
   } rsp_payload_type;

   // Per-position recipe: value = A + round((B - A) * weight)
   typedef struct packed {
      logic [SEL_BITS-1:0]  src_a;
      logic [SEL_BITS-1:0]  src_b;
      logic                 use_src;
      logic [FRAC_BITS-1:0] weight;
   } plan_type;

   // Per-output routing: which position drives it, if any
   typedef struct packed {
      logic [POS_BITS-1:0] owner;
      logic                used;
   } route_type;

   typedef plan_type  [NUM_POSITIONS-1:0] plan_vec_type;
   typedef route_type [NUM_POSITIONS-1:0] route_vec_type;

   // Weight floor((num*65536 + floor(den/2)) / den) for 0 < num < den
   function automatic logic [FRAC_BITS-1:0] weight_lut(input logic [POS_BITS-1:0] num,
                                                      input logic [POS_BITS-1:0] den);
      logic [FRAC_BITS-1:0] w;
      unique case ({den, num})
         {3'd2, 3'd1}: w = 16'd32768;
         {3'd3, 3'd1}: w = 16'd21845;
         {3'd3, 3'd2}: w = 16'd43691;
         {3'd4, 3'd1}: w = 16'd16384;
         {3'd4, 3'd2}: w = 16'd32768;
         {3'd4, 3'd3}: w = 16'd49152;
         {3'd5, 3'd1}: w = 16'd13107;
         {3'd5, 3'd2}: w = 16'd26214;
         {3'd5, 3'd3}: w = 16'd39322;
         {3'd5, 3'd4}: w = 16'd52429;
         {3'd6, 3'd1}: w = 16'd10923;
         {3'd6, 3'd2}: w = 16'd21845;
         {3'd6, 3'd3}: w = 16'd32768;
         {3'd6, 3'd4}: w = 16'd43691;
         {3'd6, 3'd5}: w = 16'd54613;
         {3'd7, 3'd1}: w = 16'd9362;
         {3'd7, 3'd2}: w = 16'd18725;
         {3'd7, 3'd3}: w = 16'd28087;
         {3'd7, 3'd4}: w = 16'd37449;
         {3'd7, 3'd5}: w = 16'd46811;
         {3'd7, 3'd6}: w = 16'd56174;
         default:      w = '0;
      endcase
      return w;
   endfunction

endpackage

### design/missing_channel_interpolator.sv
// Missing-channel interpolator: top level with configuration registers and datapath.
// Depends on mci_pkg and mci_plan.
//
// Usage:
//  - req channel: one frame of eight signed samples per request, taken at an edge
//    with req_valid high and req_stall low.
//  - rsp channel: one frame of eight output samples per request, in order.
//  - csr port: csr_write with csr_index / csr_wdata writes provided_mask (0),
//    source_select (1) or dest_select (2); other indexes are ignored. Write only
//    while no request is in flight.
//  - Pipeline: an accepted request passes the input register, source select and
//    difference, multiply and round/route stages before it reaches rsp_valid.
//  - Throughput: one frame per cycle while rsp_stall is low; the single 17x17
//    multiply per position is the deepest stage.
//  - Reset: all stage valids clear and the registers take their reset values
//    (positions 0, 3 and 7 provided, identity source and destination maps).
//  - Stall: a stalled rsp holds its frame; bubbles in the pipe still fill up, and
//    req_stall rises only when every stage holds a frame.
module missing_channel_interpolator import mci_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [MASK_BITS-1:0]   provided_mask_ff;
   logic [SELECT_BITS-1:0] source_select_ff;
   logic [SELECT_BITS-1:0] dest_select_ff;
   plan_vec_type           plan_in;
   plan_vec_type           plan_ff;
   route_vec_type          route_in;
   route_vec_type          route_ff;

   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   req_payload_type                    req_ff;
   sample_type                         smp1 [NUM_POSITIONS];
   sample_type                         a2_in [NUM_POSITIONS];
   sample_type                         a2_ff [NUM_POSITIONS];
   logic signed [SAMPLE_BITS:0]        diff2_in [NUM_POSITIONS];
   logic signed [SAMPLE_BITS:0]        diff2_ff [NUM_POSITIONS];
   logic [FRAC_BITS-1:0]               w2_ff [NUM_POSITIONS];
   sample_type                         a3_ff [NUM_POSITIONS];
   logic signed [PROD_BITS-1:0]        prod3_in [NUM_POSITIONS];
   logic signed [PROD_BITS-1:0]        prod3_ff [NUM_POSITIONS];
   sample_type                         val4 [NUM_POSITIONS];
   sample_type                         out4_in [NUM_POSITIONS];
   rsp_payload_type                    rsp_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         provided_mask_ff <= PROVIDED_MASK_RESET;
         source_select_ff <= SELECT_RESET;
         dest_select_ff   <= SELECT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PROVIDED_MASK: provided_mask_ff <= csr_wdata[MASK_BITS-1:0];
            CSR_SOURCE_SELECT: source_select_ff <= csr_wdata[SELECT_BITS-1:0];
            CSR_DEST_SELECT:   dest_select_ff   <= csr_wdata[SELECT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Recipe derived from the registers, then registered
   mci_plan u_plan (
      .provided_mask (provided_mask_ff),
      .source_select (source_select_ff),
      .dest_select   (dest_select_ff),
      .plan          (plan_in),
      .route         (route_in)
   );

   always_ff @(posedge clock) begin
      plan_ff  <= plan_in;
      route_ff <= route_in;
   end

   // Stage enables: a stage moves when empty or when the next one moves
   assign en4       = !v4_ff || !rsp_stall;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: request register
   always_ff @(posedge clock) begin
      if (en1) req_ff <= req_payload;
   end

   assign smp1[0] = req_ff.sample_in_0;
   assign smp1[1] = req_ff.sample_in_1;
   assign smp1[2] = req_ff.sample_in_2;
   assign smp1[3] = req_ff.sample_in_3;
   assign smp1[4] = req_ff.sample_in_4;
   assign smp1[5] = req_ff.sample_in_5;
   assign smp1[6] = req_ff.sample_in_6;
   assign smp1[7] = req_ff.sample_in_7;

   // Stage 2: pick the two neighbor samples and take their difference
   always_comb begin
      sample_type b_val;
      for (int p = 0; p < NUM_POSITIONS; p++) begin
         a2_in[p] = plan_ff[p].use_src ? smp1[plan_ff[p].src_a] : '0;
         b_val    = plan_ff[p].use_src ? smp1[plan_ff[p].src_b] : '0;
         diff2_in[p] = {b_val[SAMPLE_BITS-1], b_val} - {a2_in[p][SAMPLE_BITS-1], a2_in[p]};
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int p = 0; p < NUM_POSITIONS; p++) begin
            a2_ff[p]    <= a2_in[p];
            diff2_ff[p] <= diff2_in[p];
            w2_ff[p]    <= plan_ff[p].weight;
         end
      end
   end

   // Stage 3: difference times weight
   always_comb begin
      logic signed [FRAC_BITS:0] w_ext;
      for (int p = 0; p < NUM_POSITIONS; p++) begin
         w_ext       = {1'b0, w2_ff[p]};
         prod3_in[p] = diff2_ff[p] * w_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         for (int p = 0; p < NUM_POSITIONS; p++) begin
            a3_ff[p]    <= a2_ff[p];
            prod3_ff[p] <= prod3_in[p];
         end
      end
   end

   // Stage 4: round to nearest, add the left value, route to outputs
   always_comb begin
      logic signed [PROD_BITS-1:0] rounded;
      logic [SAMPLE_BITS:0]        sum;
      for (int p = 0; p < NUM_POSITIONS; p++) begin
         rounded = (prod3_ff[p] + ROUND_HALF) >>> FRAC_BITS;
         sum     = {a3_ff[p][SAMPLE_BITS-1], a3_ff[p]} + rounded[SAMPLE_BITS:0];
         val4[p] = sum[SAMPLE_BITS-1:0];
      end
      for (int j = 0; j < NUM_POSITIONS; j++) begin
         out4_in[j] = route_ff[j].used ? val4[route_ff[j].owner] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rsp_ff.sample_out_0 <= out4_in[0];
         rsp_ff.sample_out_1 <= out4_in[1];
         rsp_ff.sample_out_2 <= out4_in[2];
         rsp_ff.sample_out_3 <= out4_in[3];
         rsp_ff.sample_out_4 <= out4_in[4];
         rsp_ff.sample_out_5 <= out4_in[5];
         rsp_ff.sample_out_6 <= out4_in[6];
         rsp_ff.sample_out_7 <= out4_in[7];
      end
   end

   assign rsp_valid   = v4_ff;
   assign rsp_payload = rsp_ff;

endmodule

### design/mci_plan.sv
// Turns the configuration registers into a per-position recipe and per-output routing.
// Depends on mci_pkg (types, weight table).
module mci_plan import mci_pkg::*; (
   input  logic [MASK_BITS-1:0]   provided_mask,
   input  logic [SELECT_BITS-1:0] source_select,
   input  logic [SELECT_BITS-1:0] dest_select,
   output plan_vec_type           plan,
   output route_vec_type          route
);

   // Neighbor search and weight lookup for each position
   always_comb begin : plan_build
      logic                has_l;
      logic                has_r;
      logic [POS_BITS-1:0] l_pos;
      logic [POS_BITS-1:0] r_pos;
      logic [SEL_BITS-1:0] src_p;
      logic [SEL_BITS-1:0] src_l;
      logic [SEL_BITS-1:0] src_r;
      for (int p = 0; p < NUM_POSITIONS; p++) begin
         has_l = 1'b0;
         has_r = 1'b0;
         l_pos = '0;
         r_pos = '0;
         // nearest provided position on the left
         for (int k = 0; k < NUM_POSITIONS; k++) begin
            if (k < p && provided_mask[k]) begin
               has_l = 1'b1;
               l_pos = POS_BITS'(k);
            end
         end
         // nearest provided position on the right
         for (int k = NUM_POSITIONS - 1; k >= 0; k--) begin
            if (k > p && provided_mask[k]) begin
               has_r = 1'b1;
               r_pos = POS_BITS'(k);
            end
         end
         src_p = source_select[SEL_BITS*p +: SEL_BITS];
         src_l = source_select[SEL_BITS*l_pos +: SEL_BITS];
         src_r = source_select[SEL_BITS*r_pos +: SEL_BITS];

         plan[p].src_a   = src_p;
         plan[p].src_b   = src_p;
         plan[p].use_src = 1'b1;
         plan[p].weight  = '0;
         priority if (provided_mask[p]) begin
            plan[p].src_a = src_p;
         end else if (has_l && has_r) begin
            plan[p].src_a  = src_l;
            plan[p].src_b  = src_r;
            plan[p].weight = weight_lut(POS_BITS'(p) - l_pos, r_pos - l_pos);
         end else if (has_l) begin
            plan[p].src_a = src_l;
            plan[p].src_b = src_l;
         end else if (has_r) begin
            plan[p].src_a = src_r;
            plan[p].src_b = src_r;
         end else begin
            // nothing provided: zero
            plan[p].use_src = 1'b0;
         end
      end
   end

   // Output routing: the highest position aimed at an output owns it
   always_comb begin : route_build
      for (int j = 0; j < NUM_POSITIONS; j++) begin
         route[j].used  = 1'b0;
         route[j].owner = '0;
         for (int p = 0; p < NUM_POSITIONS; p++) begin
            if (dest_select[SEL_BITS*p +: SEL_BITS] == SEL_BITS'(j)) begin
               route[j].used  = 1'b1;
               route[j].owner = POS_BITS'(p);
            end
         end
      end
   end

endmodule

### design/mci_checker.sv
// Port-level checks of the missing-channel interpolator, bound to the top level.
// Depends on mci_pkg and missing_channel_interpolator_defines.svh.
`include "missing_channel_interpolator_defines.svh"

module mci_checker import mci_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   logic req_fire;
   logic rsp_wait;
   assign req_fire = req_valid && !req_stall;
   assign rsp_wait = rsp_valid && rsp_stall;

   // accepted request, after which rsp_stall stays low at the output
   sequence s_fire_run;
      req_fire ##1 !rsp_stall [*3];
   endsequence

   // frame still offered and unchanged
   sequence s_held;
      rsp_valid && $stable(rsp_payload);
   endsequence

   // reset empties the pipe
   `MCI_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "rsp_valid after reset")

   // the input backs up only when a finished frame waits
   `MCI_ASSERT_IMPLY(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid, "req_stall, no rsp")

   // a waiting frame stays put
   `MCI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, s_held, "stalled rsp changed")

   // an accepted request reaches rsp_valid while the output does not stall
   `MCI_ASSERT_NEXT(a_latency, clock, reset, s_fire_run, rsp_valid, "request lost in pipe")

endmodule

bind missing_channel_interpolator mci_checker u_mci_checker (.*);
